// ----- src/hsl_pkg.sv -----
package hsl_pkg;

    // Default fraction width: ONE = 1 << FRAC_BITS stands for 1.0
    localparam int HSL_FRAC_BITS = 16;

    // Segment of the piecewise hue ramp
    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_HIGH,
        SEG_FALL,
        SEG_LOW
    } t_seg;

endpackage

// ----- src/hsl_levels.sv -----
// Interpolation levels v1, v2 and their clamped difference.
// Two register stages: the l*s product, then v1/v2/d.
module hsl_levels
    import hsl_pkg::*;
#(
    parameter int FRAC_BITS = HSL_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic [FRAC_BITS:0]          i_sat,
    input  logic [FRAC_BITS:0]          i_light,
    output logic signed [FRAC_BITS+2:0] o_v1,
    output logic signed [FRAC_BITS+2:0] o_v2,
    output logic [FRAC_BITS+1:0]        o_diff
);

    localparam int W = FRAC_BITS + 3;

    logic [2*FRAC_BITS+1:0]     n_prod;
    logic [FRAC_BITS:0]         r_ls;
    logic [FRAC_BITS:0]         r_sat;
    logic [FRAC_BITS:0]         r_light;
    logic signed [W-1:0]        n_v2;
    logic signed [W-1:0]        n_v1;
    logic signed [W-1:0]        n_diff;
    logic signed [W-1:0]        r_v1;
    logic signed [W-1:0]        r_v2;
    logic [FRAC_BITS+1:0]       r_diff;

    // Truncated l*s
    assign n_prod = i_light * i_sat;

    always_ff @(posedge i_clk) begin
        r_ls    <= n_prod[2*FRAC_BITS:FRAC_BITS];
        r_sat   <= i_sat;
        r_light <= i_light;
    end

    // Form v2 by lightness half, then v1 = 2l - v2, d = max(v2 - v1, 0)
    always_comb begin
        if (r_light[FRAC_BITS:FRAC_BITS-1] == 2'b00) begin
            n_v2 = W'(r_light) + W'(r_ls);
        end else begin
            n_v2 = W'(r_light) + W'(r_sat) - W'(r_ls);
        end
        n_v1   = (W'(r_light) <<< 1) - n_v2;
        n_diff = n_v2 - n_v1;
    end

    always_ff @(posedge i_clk) begin
        r_v1   <= n_v1;
        r_v2   <= n_v2;
        r_diff <= n_diff[W-1] ? '0 : n_diff[FRAC_BITS+1:0];
    end

    assign o_v1   = r_v1;
    assign o_v2   = r_v2;
    assign o_diff = r_diff;

endmodule

// ----- src/hsl_ramp.sv -----
// Hue ramp for one channel. Segment and factor are found from the hue
// point, registered in stages B and C to line up with the levels, multiplied by d,
// then the channel is formed and clamped combinationally at the output.
module hsl_ramp
    import hsl_pkg::*;
#(
    parameter int FRAC_BITS = HSL_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic [FRAC_BITS-1:0]        i_hue,
    input  logic signed [FRAC_BITS+2:0] i_v1,
    input  logic signed [FRAC_BITS+2:0] i_v2,
    input  logic [FRAC_BITS+1:0]        i_diff,
    output logic [FRAC_BITS:0]          o_chan
);

    localparam int                  W    = FRAC_BITS + 3;
    localparam logic [W-1:0]        ONE  = W'(1) << FRAC_BITS;
    localparam logic [W-1:0]        TWO  = W'(2) << FRAC_BITS;

    logic [W-1:0]               n_six;
    logic [W-1:0]               n_three;
    logic [W-1:0]               n_fall;
    t_seg                       n_seg;
    logic [FRAC_BITS:0]         n_fac;
    t_seg                       r_seg_b;
    logic [FRAC_BITS:0]         r_fac_b;
    t_seg                       r_seg_c;
    logic [FRAC_BITS:0]         r_fac_c;
    logic [2*FRAC_BITS+2:0]     n_prod;
    logic [FRAC_BITS+1:0]       r_prod;
    t_seg                       r_seg_d;
    logic signed [W-1:0]        r_v1;
    logic signed [W-1:0]        r_v2;
    logic signed [W-1:0]        n_val;

    // Pick the segment and the slope factor
    always_comb begin
        n_six   = (W'(i_hue) << 2) + (W'(i_hue) << 1);
        n_three = (W'(i_hue) << 1) + W'(i_hue);
        n_fall  = (TWO - n_three) << 1;
        n_fac   = '0;
        if (n_six < ONE) begin
            n_seg = SEG_RISE;
            n_fac = n_six[FRAC_BITS:0];
        end else if (!i_hue[FRAC_BITS-1]) begin
            n_seg = SEG_HIGH;
        end else if (n_three < TWO) begin
            n_seg = SEG_FALL;
            n_fac = n_fall[FRAC_BITS:0];
        end else begin
            n_seg = SEG_LOW;
        end
    end

    // Stage B then a delay stage C
    always_ff @(posedge i_clk) begin
        r_seg_b <= n_seg;
        r_fac_b <= n_fac;
        r_seg_c <= r_seg_b;
        r_fac_c <= r_fac_b;
    end

    // Stage D: slope product, truncated
    assign n_prod = i_diff * r_fac_c;

    always_ff @(posedge i_clk) begin
        r_prod  <= n_prod[2*FRAC_BITS+1:FRAC_BITS];
        r_seg_d <= r_seg_c;
        r_v1    <= i_v1;
        r_v2    <= i_v2;
    end

    // Select by segment and clamp to 0..ONE
    always_comb begin
        unique case (r_seg_d)
            SEG_RISE, SEG_FALL: n_val = r_v1 + signed'(W'(r_prod));
            SEG_HIGH:           n_val = r_v2;
            default:            n_val = r_v1;
        endcase
        if (n_val[W-1]) begin
            o_chan = '0;
        end else if (n_val > signed'(ONE)) begin
            o_chan = ONE[FRAC_BITS:0];
        end else begin
            o_chan = n_val[FRAC_BITS:0];
        end
    end

endmodule

// ----- src/hsl_to_rgb_convert.sv -----
// HSL plus alpha to RGB plus alpha, one pixel per clock. An item is taken
// at every edge with start high (busy is always low) and its result shows
// on the outputs with o_valid high for one cycle, after the five register
// stages (input, l*s product, levels, slope product, output). The receiver
// cannot stall the block. Hue is an unsigned fraction of a turn that wraps;
// saturation and lightness above 1.0 are taken as 1.0; channels are clamped
// to 0..1.0 and alpha passes through.
module hsl_to_rgb_convert
    import hsl_pkg::*;
#(
    parameter int FRAC_BITS = HSL_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [FRAC_BITS-1:0] i_hue,
    input  logic [FRAC_BITS:0]  i_saturation,
    input  logic [FRAC_BITS:0]  i_lightness,
    input  logic [FRAC_BITS:0]  i_alpha_in,
    output logic                o_valid,
    output logic [FRAC_BITS:0]  o_red,
    output logic [FRAC_BITS:0]  o_green,
    output logic [FRAC_BITS:0]  o_blue,
    output logic [FRAC_BITS:0]  o_alpha_out
);

    localparam logic [FRAC_BITS:0]   ONE   = (FRAC_BITS + 1)'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS-1:0] THIRD = FRAC_BITS'((1 << FRAC_BITS) / 3);

    logic                   n_accept;
    logic                   r_vld_a;
    logic                   r_vld_b;
    logic                   r_vld_c;
    logic                   r_vld_d;
    logic                   r_vld_e;
    logic [FRAC_BITS-1:0]   r_hue_r;
    logic [FRAC_BITS-1:0]   r_hue_g;
    logic [FRAC_BITS-1:0]   r_hue_b;
    logic [FRAC_BITS:0]     r_sat;
    logic [FRAC_BITS:0]     r_light [4];
    logic [FRAC_BITS:0]     r_alpha [4];
    logic                   r_grey  [4];
    logic signed [FRAC_BITS+2:0] w_v1;
    logic signed [FRAC_BITS+2:0] w_v2;
    logic [FRAC_BITS+1:0]   w_diff;
    logic [FRAC_BITS:0]     w_red;
    logic [FRAC_BITS:0]     w_green;
    logic [FRAC_BITS:0]     w_blue;
    logic [FRAC_BITS:0]     r_red;
    logic [FRAC_BITS:0]     r_green;
    logic [FRAC_BITS:0]     r_blue;
    logic [FRAC_BITS:0]     r_alpha_out;
    logic [FRAC_BITS:0]     n_sat;
    logic [FRAC_BITS:0]     n_light;

    assign busy     = 1'b0;
    assign n_accept = start && !busy;

    // Saturate inputs above ONE
    assign n_sat   = (i_saturation > ONE) ? ONE : i_saturation;
    assign n_light = (i_lightness  > ONE) ? ONE : i_lightness;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
            r_vld_e <= 1'b0;
        end else begin
            r_vld_a <= n_accept;
            r_vld_b <= r_vld_a;
            r_vld_c <= r_vld_b;
            r_vld_d <= r_vld_c;
            r_vld_e <= r_vld_d;
        end
    end

    // Stage A: capture the beat, offset hue by a third each way
    always_ff @(posedge i_clk) begin
        r_hue_r    <= i_hue + THIRD;
        r_hue_g    <= i_hue;
        r_hue_b    <= i_hue - THIRD;
        r_sat      <= n_sat;
        r_light[0] <= n_light;
        r_alpha[0] <= i_alpha_in;
        r_grey[0]  <= (n_sat == '0);
    end

    // Carry grey level, grey flag and alpha alongside the pipeline
    always_ff @(posedge i_clk) begin
        for (int i = 1; i < 4; i++) begin
            r_light[i] <= r_light[i-1];
            r_alpha[i] <= r_alpha[i-1];
            r_grey[i]  <= r_grey[i-1];
        end
    end

    hsl_levels #(.FRAC_BITS(FRAC_BITS)) u_levels (
        .i_clk   (i_clk),
        .i_sat   (r_sat),
        .i_light (r_light[0]),
        .o_v1    (w_v1),
        .o_v2    (w_v2),
        .o_diff  (w_diff)
    );

    hsl_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp_red (
        .i_clk  (i_clk),
        .i_hue  (r_hue_r),
        .i_v1   (w_v1),
        .i_v2   (w_v2),
        .i_diff (w_diff),
        .o_chan (w_red)
    );

    hsl_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp_green (
        .i_clk  (i_clk),
        .i_hue  (r_hue_g),
        .i_v1   (w_v1),
        .i_v2   (w_v2),
        .i_diff (w_diff),
        .o_chan (w_green)
    );

    hsl_ramp #(.FRAC_BITS(FRAC_BITS)) u_ramp_blue (
        .i_clk  (i_clk),
        .i_hue  (r_hue_b),
        .i_v1   (w_v1),
        .i_v2   (w_v2),
        .i_diff (w_diff),
        .o_chan (w_blue)
    );

    // Stage E: output registers, grey overrides the ramps
    always_ff @(posedge i_clk) begin
        r_red       <= r_grey[3] ? r_light[3] : w_red;
        r_green     <= r_grey[3] ? r_light[3] : w_green;
        r_blue      <= r_grey[3] ? r_light[3] : w_blue;
        r_alpha_out <= r_alpha[3];
    end

    assign o_valid     = r_vld_e;
    assign o_red       = r_red;
    assign o_green     = r_green;
    assign o_blue      = r_blue;
    assign o_alpha_out = r_alpha_out;

`ifndef SYNTH
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_valid)
        else $error("accepted beat did not come out after five cycles");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_red <= ONE && o_green <= ONE && o_blue <= ONE))
        else $error("channel above full scale");

    a_grey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_saturation == '0) |-> ##5
        (o_red == o_green && o_green == o_blue))
        else $error("zero saturation did not give grey");

    a_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 (o_alpha_out == $past(i_alpha_in, 5)))
        else $error("alpha not passed through");
`endif

endmodule

// ----- dv/hsl_to_rgb_convert_test.sv -----
`timescale 1ns / 100ps

module hsl_to_rgb_convert_test;
    import hsl_pkg::*;

    localparam int FB = HSL_FRAC_BITS;
    localparam longint ONE = longint'(1) << FB;
    localparam longint THIRD = ONE / 3;
    localparam logic [FB:0] ONE_F = (FB + 1)'(1) << FB;
    localparam logic [FB:0] HALF_F = (FB + 1)'(1) << (FB - 1);
    localparam logic [FB:0] LSB_F = (FB + 1)'(1);

    // One converted pixel as it leaves the block
    typedef struct packed {
        logic [FB:0] red;
        logic [FB:0] green;
        logic [FB:0] blue;
        logic [FB:0] alpha;
    } t_rgba;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [FB-1:0]     i_hue = '0;
    logic [FB:0]       i_saturation = '0;
    logic [FB:0]       i_lightness = '0;
    logic [FB:0]       i_alpha_in = '0;
    logic              o_valid;
    logic [FB:0]       o_red;
    logic [FB:0]       o_green;
    logic [FB:0]       o_blue;
    logic [FB:0]       o_alpha_out;

    t_rgba pending_rgba[$];
    int    err_count = 0;
    bit    sender_gaps = 1'b1;

    hsl_to_rgb_convert #(
        .FRAC_BITS(FB)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_hue(i_hue),
        .i_saturation(i_saturation),
        .i_lightness(i_lightness),
        .i_alpha_in(i_alpha_in),
        .o_valid(o_valid),
        .o_red(o_red),
        .o_green(o_green),
        .o_blue(o_blue),
        .o_alpha_out(o_alpha_out)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run
    initial begin
        #5_000_000;
        $display("hsl_to_rgb_convert_test: done, errors");
        $finish;
    end

    // Piecewise hue ramp between the two levels at hue point vh
    function automatic longint ramp_level(longint v1, longint v2, longint vh);
        longint d;
        d = v2 - v1;
        if (d < 0) d = 0;
        if (6 * vh < ONE) return v1 + ((d * 6 * vh) >> FB);
        if (2 * vh < ONE) return v2;
        if (3 * vh < 2 * ONE) return v1 + ((d * 2 * (2 * ONE - 3 * vh)) >> FB);
        return v1;
    endfunction

    function automatic logic [FB:0] clamp_channel(longint v);
        if (v < 0) return '0;
        if (v > ONE) return ONE_F;
        return v[FB:0];
    endfunction

    // Compute the RGB color and alpha for one HSL pixel
    function automatic t_rgba predict_rgba(logic [FB-1:0] hue, logic [FB:0] sat,
                                           logic [FB:0] light, logic [FB:0] alpha);
        longint h, s, l, ls, v1, v2, hr, hb;
        t_rgba res;
        h = hue;
        s = sat;
        l = light;
        if (s > ONE) s = ONE;
        if (l > ONE) l = ONE;
        if (s == 0) begin
            res.red = clamp_channel(l);
            res.green = clamp_channel(l);
            res.blue = clamp_channel(l);
        end else begin
            ls = (l * s) >> FB;
            v2 = (2 * l < ONE) ? l + ls : l + s - ls;
            v1 = 2 * l - v2;
            hr = (h + THIRD) & (ONE - 1);
            hb = (h + ONE - THIRD) & (ONE - 1);
            res.red = clamp_channel(ramp_level(v1, v2, hr));
            res.green = clamp_channel(ramp_level(v1, v2, h));
            res.blue = clamp_channel(ramp_level(v1, v2, hb));
        end
        res.alpha = alpha;
        return res;
    endfunction

    // Draw a fraction, weighted toward zero, one, one half and overrange
    function automatic logic [FB:0] pick_fraction();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ONE_F;
            2: return r[FB:0];
            3: return ONE_F - (FB + 1)'($urandom_range(1, 64));
            4: return HALF_F + (FB + 1)'($urandom_range(0, 8)) - (FB + 1)'(4);
            default: return (FB + 1)'($urandom_range(0, 32'(ONE)));
        endcase
    endfunction

    // Draw a hue, sometimes right at a ramp segment boundary
    function automatic logic [FB-1:0] pick_hue();
        longint edge_pt;
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 5))
            0: edge_pt = ONE / 6;
            1: edge_pt = ONE / 2;
            2: edge_pt = (2 * ONE) / 3;
            3: edge_pt = THIRD;
            default: return r[FB-1:0];
        endcase
        edge_pt = edge_pt + $urandom_range(0, 6) - 3;
        return edge_pt[FB-1:0];
    endfunction

    // Drive one pixel and hold it until the block takes the beat
    task automatic send_pixel(logic [FB-1:0] hue, logic [FB:0] sat,
                              logic [FB:0] light, logic [FB:0] alpha);
        int gap;
        gap = sender_gaps ? int'($urandom_range(0, 16)) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_hue <= hue;
        i_saturation <= sat;
        i_lightness <= light;
        i_alpha_in <= alpha;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_rgba.push_back(predict_rgba(hue, sat, light, alpha));
    endtask

    // Stall until every expected pixel has come out
    task automatic wait_drained();
        do @(posedge i_clk); while (pending_rgba.size() > 0);
    endtask

    task automatic check_field(string name, logic [FB:0] want, logic [FB:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    // Compare each output beat against the oldest prediction
    always @(posedge i_clk) begin
        t_rgba want;
        if (i_rst_n) begin
            if ($isunknown(o_valid)) begin
                $display("%0t: o_valid mismatch: expected 0 or 1, actual %b", $time, o_valid);
                err_count++;
            end else if (o_valid) begin
                if (pending_rgba.size() == 0) begin
                    $display("%0t: output beat mismatch: expected none, actual r=%0d g=%0d b=%0d a=%0d",
                             $time, o_red, o_green, o_blue, o_alpha_out);
                    err_count++;
                end else begin
                    want = pending_rgba.pop_front();
                    check_field("red", want.red, o_red);
                    check_field("green", want.green, o_green);
                    check_field("blue", want.blue, o_blue);
                    check_field("alpha", want.alpha, o_alpha_out);
                end
            end
        end
    end

    // Grey levels, segment boundaries of the ramp and overrange inputs
    task automatic test_directed();
        sender_gaps = 1'b1;
        send_pixel(16'h0000, '0, '0, '0);
        send_pixel(16'hFFFF, '0, ONE_F, ONE_F);
        send_pixel(16'h1234, '0, 17'h1FFFF, 17'h1FFFF);
        send_pixel(16'h5555, '0, 17'h12345, 17'h0FFFF);
        send_pixel(16'd0, ONE_F, HALF_F, 17'd1);
        send_pixel(16'd10922, ONE_F, HALF_F, ONE_F);
        send_pixel(16'd10923, ONE_F, HALF_F, ONE_F);
        send_pixel(16'd21845, ONE_F, HALF_F, ONE_F);
        send_pixel(16'd32767, ONE_F, HALF_F, ONE_F);
        send_pixel(16'd32768, ONE_F, HALF_F, ONE_F);
        send_pixel(16'd43690, ONE_F, HALF_F, ONE_F);
        send_pixel(16'd43691, ONE_F, HALF_F, ONE_F);
        send_pixel(16'hFFFF, ONE_F, HALF_F, ONE_F);
        send_pixel(16'h2000, 17'h1FFFF, 17'h1FFFF, 17'h10001);
        send_pixel(16'h8000, 17'd1, HALF_F - LSB_F, 17'h0AAAA);
        send_pixel(16'h8000, ONE_F, HALF_F - LSB_F, 17'h15555);
        send_pixel(16'h4000, ONE_F, HALF_F, 17'h00000);
        send_pixel(16'h4000, ONE_F, HALF_F + LSB_F, 17'h1FFFF);
        send_pixel(16'hC000, ONE_F, ONE_F, ONE_F);
        send_pixel(16'hC000, ONE_F, 17'd1, ONE_F);
        send_pixel(16'hAAAA, 17'h10001, 17'h08000, 17'h10000);
        send_pixel(16'h5555, 17'h08000, 17'h18000, 17'h00001);
    endtask

    // Random pixels with random sender gaps
    task automatic test_random_gaps();
        sender_gaps = 1'b1;
        repeat (700) send_pixel(pick_hue(), pick_fraction(), pick_fraction(), pick_fraction());
    endtask

    // Random pixels back to back, one per clock
    task automatic test_back_to_back();
        sender_gaps = 1'b0;
        repeat (600) send_pixel(pick_hue(), pick_fraction(), pick_fraction(), pick_fraction());
    endtask

    // Let the pipeline empty out, then restart with a burst
    task automatic test_drain_pause();
        repeat (5) begin
            start <= 1'b0;
            wait_drained();
            sender_gaps = 1'($urandom_range(0, 1));
            repeat (50) send_pixel(pick_hue(), pick_fraction(), pick_fraction(),
                                   pick_fraction());
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_gaps();
        test_back_to_back();
        test_drain_pause();
        start <= 1'b0;
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("hsl_to_rgb_convert_test: done, clean");
        end else begin
            $display("hsl_to_rgb_convert_test: done, errors");
        end
        $finish;
    end

endmodule
